FILE: rtl/core/cbc_pkg.sv
package cbc_pkg;

    localparam int RAM_BANKS_DEF  = 4;
    localparam int RAM_BANK_ROWS  = 4096;   // 8 KiB bank split over two byte-wide halves
    localparam int ROW_MAX_W      = 14;
    localparam int ROM_ADDR_W     = 21;
    localparam int FIFO_DEPTH     = 2;

    localparam logic       CMD_READ  = 1'b0;
    localparam logic       CMD_WRITE = 1'b1;

    localparam logic       STATUS_OK       = 1'b0;
    localparam logic       STATUS_UNMAPPED = 1'b1;

    localparam logic [1:0] TGT_ROM  = 2'd0;
    localparam logic [1:0] TGT_RAM  = 2'd1;
    localparam logic [1:0] TGT_CTRL = 2'd2;

    // Control register windows, selected by address bits 14:13.
    localparam logic [1:0] CTL_RAM_ENABLE = 2'd0;
    localparam logic [1:0] CTL_ROM_LOW    = 2'd1;
    localparam logic [1:0] CTL_BANK_HIGH  = 2'd2;
    localparam logic [1:0] CTL_MODE       = 2'd3;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
    localparam logic [6:0] ROM_BANK_RESET = 7'd1;

    typedef struct packed {
        logic                    is_ram;
        logic                    cmd;
        logic                    word;
        logic                    ram_en;
        logic                    lo_odd;
        logic [ROW_MAX_W-1:0]    row_even;
        logic [ROW_MAX_W-1:0]    row_odd;
        logic [15:0]             write_value;
        logic                    status;
        logic [1:0]              target;
        logic [ROM_ADDR_W-1:0]   rom_address;
        logic [15:0]             prev;
    } entry_t;

endpackage

FILE: rtl/core/cbc_front.sv
module cbc_front
    import cbc_pkg::*;
#(
    parameter int RAM_BANKS = RAM_BANKS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic         cmd,
    input  logic         word_access,
    input  logic [15:0]  bus_address,
    input  logic [15:0]  write_value,
    output entry_t       entry
);

    logic [6:0]  rom_bank_reg, rom_bank_next;
    logic [1:0]  ram_bank_reg, ram_bank_next;
    logic        rom_mode_reg, rom_mode_next;
    logic        ram_en_reg, ram_en_next;

    logic        ram_hit;
    logic        unmapped;
    logic        ctrl_write;
    logic [1:0]  bank_eff;
    logic [12:0] off0;
    logic [12:0] off1;
    logic [12:0] even_off;
    logic [12:0] odd_off;
    logic [4:0]  low5;

    assign ram_hit    = (bus_address[15:13] == 3'b101);
    assign unmapped   = bus_address[15] && !ram_hit;
    assign ctrl_write = !bus_address[15] && (cmd == CMD_WRITE);

    always_comb
    begin
        if (RAM_BANKS == 1)
        begin
            bank_eff = 2'd0;
        end
        else if (int'(ram_bank_reg) >= RAM_BANKS)
        begin
            bank_eff = ram_bank_reg - 2'(RAM_BANKS);
        end
        else
        begin
            bank_eff = ram_bank_reg;
        end
    end

    // A word access always touches one even and one odd byte, even when it wraps
    // at the end of a bank, so each byte-wide half sees at most one row.
    assign off0     = bus_address[12:0];
    assign off1     = off0 + 13'd1;
    assign even_off = off0[0] ? off1 : off0;
    assign odd_off  = off0[0] ? off0 : off1;

    assign low5 = (write_value[4:0] == 5'd0) ? 5'd1 : write_value[4:0];

    always_comb
    begin
        entry             = '0;
        entry.cmd         = cmd;
        entry.word        = word_access;
        entry.write_value = write_value;
        entry.ram_en      = ram_en_reg;
        entry.lo_odd      = off0[0];
        entry.row_even    = {bank_eff, even_off[12:1]};
        entry.row_odd     = {bank_eff, odd_off[12:1]};
        entry.status      = STATUS_OK;
        entry.target      = TGT_ROM;

        if (ram_hit)
        begin
            entry.is_ram = 1'b1;
            entry.target = TGT_RAM;
        end
        else if (unmapped)
        begin
            entry.status = STATUS_UNMAPPED;
        end
        else if (cmd == CMD_READ)
        begin
            if (!bus_address[14])
            begin
                entry.rom_address = {5'd0, bus_address};
            end
            else
            begin
                entry.rom_address = {rom_bank_reg, bus_address[13:0]};
            end
        end
        else
        begin
            entry.target = TGT_CTRL;
            case (bus_address[14:13])
                CTL_RAM_ENABLE: entry.prev = {15'd0, ram_en_reg};
                CTL_ROM_LOW:    entry.prev = {9'd0, rom_bank_reg};
                default:        entry.prev = 16'd0;
            endcase
        end
    end

    always_comb
    begin
        rom_bank_next = rom_bank_reg;
        ram_bank_next = ram_bank_reg;
        rom_mode_next = rom_mode_reg;
        ram_en_next   = ram_en_reg;
        if (accept && ctrl_write)
        begin
            case (bus_address[14:13])
                CTL_RAM_ENABLE:
                begin
                    ram_en_next = (write_value[3:0] == RAM_ENABLE_KEY);
                end
                CTL_ROM_LOW:
                begin
                    rom_bank_next = {rom_bank_reg[6:5], low5};
                end
                CTL_BANK_HIGH:
                begin
                    if (!rom_mode_reg)
                    begin
                        ram_bank_next = write_value[1:0];
                    end
                    else
                    begin
                        rom_bank_next = {write_value[1:0], rom_bank_reg[4:0]};
                    end
                end
                CTL_MODE:
                begin
                    rom_mode_next = !write_value[0];
                end
                default:
                begin
                    rom_mode_next = rom_mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg <= ROM_BANK_RESET;
            ram_bank_reg <= 2'd0;
            rom_mode_reg <= 1'b1;
            ram_en_reg   <= 1'b0;
        end
        else
        begin
            rom_bank_reg <= rom_bank_next;
            ram_bank_reg <= ram_bank_next;
            rom_mode_reg <= rom_mode_next;
            ram_en_reg   <= ram_en_next;
        end
    end

endmodule

FILE: rtl/core/cbc_fifo.sv
module cbc_fifo
    import cbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  din,
    input  logic    pop,
    output entry_t  dout,
    output logic    empty,
    output logic    full
);

    entry_t      slot_reg [FIFO_DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'(FIFO_DEPTH));
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/cbc_back.sv
module cbc_back
    import cbc_pkg::*;
#(
    parameter int RAM_BANKS = RAM_BANKS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  entry_t                  head,
    input  logic                    empty,
    output logic                    pop,
    output logic                    clearing,
    output logic                    done,
    output logic                    status,
    output logic [1:0]              target,
    output logic [ROM_ADDR_W-1:0]   rom_address,
    output logic [15:0]             read_data,
    output logic [15:0]             previous_value
);

    localparam int ROWS  = RAM_BANKS * RAM_BANK_ROWS;
    localparam int ROW_W = $clog2(ROWS);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_RESP  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [ROW_W-1:0]    clear_cnt_reg, clear_cnt_next;
    entry_t              op_reg;

    logic [7:0]          mem_even [ROWS];
    logic [7:0]          mem_odd  [ROWS];
    logic [7:0]          rd_even_reg;
    logic [7:0]          rd_odd_reg;

    logic                done_reg;
    logic                status_reg;
    logic [1:0]          target_reg;
    logic [ROM_ADDR_W-1:0] rom_address_reg;
    logic [15:0]         read_data_reg;
    logic [15:0]         previous_value_reg;

    logic                clear_go;
    logic                resp_go;
    logic                wr_go;
    logic [7:0]          low_byte;
    logic [7:0]          high_byte;
    logic [15:0]         old_value;
    logic                we_even, we_odd;
    logic [ROW_W-1:0]    wa_even, wa_odd;
    logic [7:0]          wd_even, wd_odd;

    assign clear_go = (state_reg == ST_CLEAR);
    assign resp_go  = (state_reg == ST_RESP);
    assign pop      = (state_reg == ST_IDLE) && !empty;
    assign clearing = clear_go;

    assign low_byte  = op_reg.lo_odd ? rd_odd_reg : rd_even_reg;
    assign high_byte = op_reg.lo_odd ? rd_even_reg : rd_odd_reg;
    assign old_value = op_reg.word ? {high_byte, low_byte} : {8'd0, low_byte};

    assign wr_go = resp_go && op_reg.is_ram && (op_reg.cmd == CMD_WRITE) && op_reg.ram_en;

    // The low byte goes to the half that holds the first index; the high byte of
    // a word write lands in the other half.
    assign we_even = clear_go || (wr_go && (!op_reg.lo_odd || op_reg.word));
    assign we_odd  = clear_go || (wr_go && (op_reg.lo_odd || op_reg.word));
    assign wa_even = clear_go ? clear_cnt_reg : op_reg.row_even[ROW_W-1:0];
    assign wa_odd  = clear_go ? clear_cnt_reg : op_reg.row_odd[ROW_W-1:0];
    assign wd_even = clear_go ? 8'd0 :
                     (op_reg.lo_odd ? op_reg.write_value[15:8] : op_reg.write_value[7:0]);
    assign wd_odd  = clear_go ? 8'd0 :
                     (op_reg.lo_odd ? op_reg.write_value[7:0] : op_reg.write_value[15:8]);

    always_ff @(posedge clk)
    begin
        if (we_even)
        begin
            mem_even[wa_even] <= wd_even;
        end
        if (pop)
        begin
            rd_even_reg <= mem_even[head.row_even[ROW_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_odd)
        begin
            mem_odd[wa_odd] <= wd_odd;
        end
        if (pop)
        begin
            rd_odd_reg <= mem_odd[head.row_odd[ROW_W-1:0]];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clear_cnt_next = clear_cnt_reg + ROW_W'(1);
                if (clear_cnt_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!empty)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg <= head;
        end
        if (resp_go)
        begin
            status_reg      <= op_reg.status;
            target_reg      <= op_reg.target;
            rom_address_reg <= op_reg.rom_address;
            if (op_reg.is_ram)
            begin
                read_data_reg      <= (op_reg.cmd == CMD_READ) ? old_value : 16'd0;
                previous_value_reg <= (op_reg.cmd == CMD_WRITE) ? old_value : 16'd0;
            end
            else
            begin
                read_data_reg      <= 16'd0;
                previous_value_reg <= op_reg.prev;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            done_reg      <= resp_go;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign target         = target_reg;
    assign rom_address    = rom_address_reg;
    assign read_data      = read_data_reg;
    assign previous_value = previous_value_reg;

endmodule

FILE: rtl/core/cartridge_bank_controller_core.sv
// An accepted beat waits in the queue, then in the back end's op register; its result is
// strobed on done from the result registers. Each beat is read, then written, before the next pop.
// A two-entry queue lets start be taken while the back end is still working.
// Reset restores the control registers, then clears the RAM row by row with busy high.
// The receiver cannot stall; each result shows for one cycle only.
module cartridge_bank_controller_core
    import cbc_pkg::*;
#(
    parameter int RAM_BANKS = RAM_BANKS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    cmd,
    input  logic                    word_access,
    input  logic [15:0]             bus_address,
    input  logic [15:0]             write_value,
    output logic                    done,
    output logic                    status,
    output logic [1:0]              target,
    output logic [ROM_ADDR_W-1:0]   rom_address,
    output logic [15:0]             read_data,
    output logic [15:0]             previous_value
);

    logic    accept;
    entry_t  front_entry;
    entry_t  head_entry;
    logic    q_empty;
    logic    q_full;
    logic    q_pop;
    logic    clearing;

    assign busy   = q_full || clearing;
    assign accept = start && !busy;

    cbc_front #(
        .RAM_BANKS (RAM_BANKS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cmd         (cmd),
        .word_access (word_access),
        .bus_address (bus_address),
        .write_value (write_value),
        .entry       (front_entry)
    );

    cbc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .din   (front_entry),
        .pop   (q_pop),
        .dout  (head_entry),
        .empty (q_empty),
        .full  (q_full)
    );

    cbc_back #(
        .RAM_BANKS (RAM_BANKS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head_entry),
        .empty          (q_empty),
        .pop            (q_pop),
        .clearing       (clearing),
        .done           (done),
        .status         (status),
        .target         (target),
        .rom_address    (rom_address),
        .read_data      (read_data),
        .previous_value (previous_value)
    );

`ifndef SYNTHESIS
    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !done)
        else $error("result strobed during RAM clearing");

    a_unmapped_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_UNMAPPED) |->
            (target == TGT_ROM && rom_address == '0 && read_data == 16'd0
             && previous_value == 16'd0))
        else $error("unmapped access returned nonzero fields");

    a_accept_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !q_empty || $past(q_pop) || done || q_pop)
        else $error("accepted beat lost before the back end");

    a_pop_only_when_queued: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty && !clearing)
        else $error("back end popped without a queued beat");
`endif

endmodule
